// ===== rtl/round_robin_slice_scheduler_top_assert.svh =====
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_TOP_ASSERT_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RRSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrss check failed");
`define RRSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrss check failed");
`else
`define RRSS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RRSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/rrss_pkg.sv =====
package rrss_pkg;

   localparam int BURST_W  = 16;
   localparam int CLOCK_W  = 21;
   localparam int START_W  = 20;
   localparam int ACC_W    = 24;
   localparam int WAIT_W   = 25;
   localparam int SLOT_O_W = 4;
   localparam int COUNT_W  = 5;
   localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_CALC,
      ST_COMMIT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_FULL,
      KIND_NONE,
      KIND_RUN
   } kind_type;

   typedef struct packed {
      logic     capture;
      logic     add_commit;
      logic     scan_step;
      logic     calc;
      logic     commit;
      logic     emit;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic table_full;
      logic scan_hit;
      logic scan_last;
   } status_type;

endpackage

// ===== rtl/rrss_ctrl.sv =====
module rrss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                run_req,
   input  rrss_pkg::status_type status,
   output rrss_pkg::cmd_type   cmd,
   output logic                busy
);

   rrss_pkg::state_type state_ff, state_in;
   rrss_pkg::kind_type  kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrss_pkg::ST_IDLE;
         kind_ff  <= rrss_pkg::KIND_ADD;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrss_pkg::ST_IDLE: begin
            if (start) begin
               state_in = run_req ? rrss_pkg::ST_SCAN : rrss_pkg::ST_ADD;
            end
         end
         rrss_pkg::ST_ADD:    state_in = rrss_pkg::ST_EMIT;
         rrss_pkg::ST_SCAN: begin
            priority if (status.scan_hit) begin
               state_in = rrss_pkg::ST_CALC;
            end else if (status.scan_last) begin
               state_in = rrss_pkg::ST_EMIT;
            end
         end
         rrss_pkg::ST_CALC:   state_in = rrss_pkg::ST_COMMIT;
         rrss_pkg::ST_COMMIT: state_in = rrss_pkg::ST_EMIT;
         rrss_pkg::ST_EMIT:   state_in = rrss_pkg::ST_IDLE;
         default:             state_in = rrss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.kind = kind_ff;
      kind_in  = kind_ff;
      busy     = 1'b1;
      unique case (state_ff)
         rrss_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         rrss_pkg::ST_ADD: begin
            cmd.add_commit = 1'b1;
            kind_in = status.table_full ? rrss_pkg::KIND_FULL : rrss_pkg::KIND_ADD;
         end
         rrss_pkg::ST_SCAN: begin
            priority if (status.scan_hit) begin
               kind_in = rrss_pkg::KIND_RUN;
            end else if (status.scan_last) begin
               kind_in = rrss_pkg::KIND_NONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         rrss_pkg::ST_CALC:   cmd.calc   = 1'b1;
         rrss_pkg::ST_COMMIT: cmd.commit = 1'b1;
         rrss_pkg::ST_EMIT:   cmd.emit   = 1'b1;
         default:             busy       = 1'b1;
      endcase
   end

endmodule

// ===== rtl/rrss_datapath.sv =====
module rrss_datapath #(
   parameter int MAX_TASKS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rrss_pkg::cmd_type                   cmd,
   output rrss_pkg::status_type                status,
   input  logic                                csr_write,
   input  logic [rrss_pkg::BURST_W-1:0]        csr_quantum,
   input  logic [rrss_pkg::BURST_W-1:0]        req_burst_length,
   output logic                                rsp_valid,
   output logic [rrss_pkg::SLOT_O_W-1:0]       rsp_task_slot,
   output logic [rrss_pkg::BURST_W-1:0]        rsp_slice_length,
   output logic [rrss_pkg::START_W-1:0]        rsp_slice_start,
   output logic                                rsp_task_finished,
   output logic                                rsp_all_done,
   output logic                                rsp_table_full,
   output logic [rrss_pkg::COUNT_W-1:0]        rsp_task_count,
   output logic [rrss_pkg::ACC_W-1:0]          rsp_sum_turnaround,
   output logic [rrss_pkg::ACC_W-1:0]          rsp_sum_waiting,
   output logic [rrss_pkg::ACC_W-1:0]          rsp_sum_response
);

   localparam int SLOT_W = $clog2(MAX_TASKS);
   localparam int WP_W   = $clog2(MAX_TASKS + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);
   localparam logic [WP_W-1:0]   TASKS_WP  = WP_W'(MAX_TASKS);

   localparam int BW = rrss_pkg::BURST_W;
   localparam int CW = rrss_pkg::CLOCK_W;
   localparam int AW = rrss_pkg::ACC_W;
   localparam int WW = rrss_pkg::WAIT_W;

   logic [BW-1:0]        rem_mem [MAX_TASKS];
   logic [BW-1:0]        rd_data_ff;
   logic                 mem_we;
   logic [SLOT_W-1:0]    mem_addr;
   logic [BW-1:0]        mem_wdata;

   logic [BW-1:0]        quantum_ff;
   logic [BW-1:0]        burst_ff;
   logic [WP_W-1:0]      wp_ff;
   logic [SLOT_W-1:0]    tp_ff;
   logic [SLOT_W-1:0]    scan_ptr_ff, scan_ptr_in;
   logic [SLOT_W-1:0]    scan_cnt_ff;
   logic [MAX_TASKS-1:0] live_ff;
   logic [MAX_TASKS-1:0] started_ff;
   logic [CW-1:0]        clock_ff;
   logic [AW-1:0]        turn_ff;
   logic [WW-1:0]        wait_ff;
   logic [AW-1:0]        resp_ff;
   logic [BW-1:0]        slice_ff;
   logic [CW-1:0]        start_ff;
   logic [BW-1:0]        rem_next_ff;
   logic                 fin_ff;

   logic [BW-1:0]        q_eff;
   logic [BW-1:0]        slice_in;
   logic                 table_full;
   logic                 done_now;
   logic [SLOT_W-1:0]    slot_next;
   logic [SLOT_W+3:0]    slot_ext;
   logic [WP_W+4:0]      count_ext;

   assign table_full = (wp_ff >= TASKS_WP);
   assign q_eff      = (quantum_ff == '0) ? BW'(1) : quantum_ff;
   assign slice_in   = (rd_data_ff < q_eff) ? rd_data_ff : q_eff;
   assign done_now   = (rem_next_ff == '0);
   assign slot_next  = (scan_ptr_ff == LAST_SLOT) ? '0 : scan_ptr_ff + SLOT_W'(1);
   assign scan_ptr_in = cmd.capture ? tp_ff : slot_next;

   assign status.table_full = table_full;
   assign status.scan_hit   = live_ff[scan_ptr_ff];
   assign status.scan_last  = (scan_cnt_ff == LAST_SLOT);

   assign mem_we    = (cmd.add_commit && !table_full) || cmd.commit;
   assign mem_addr  = cmd.commit ? scan_ptr_ff : wp_ff[SLOT_W-1:0];
   assign mem_wdata = cmd.commit ? rem_next_ff : burst_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rem_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= rem_mem[scan_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         burst_ff <= req_burst_length;
      end
      if (cmd.calc) begin
         slice_ff    <= slice_in;
         start_ff    <= clock_ff;
         rem_next_ff <= rd_data_ff - slice_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff  <= rrss_pkg::QUANTUM_RESET;
         wp_ff       <= '0;
         tp_ff       <= '0;
         scan_ptr_ff <= '0;
         scan_cnt_ff <= '0;
         live_ff     <= '0;
         started_ff  <= '0;
         clock_ff    <= '0;
         turn_ff     <= '0;
         wait_ff     <= '0;
         resp_ff     <= '0;
         fin_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            quantum_ff <= csr_quantum;
         end
         if (cmd.capture || cmd.scan_step) begin
            scan_ptr_ff <= scan_ptr_in;
            scan_cnt_ff <= cmd.capture ? '0 : scan_cnt_ff + SLOT_W'(1);
         end
         if (cmd.add_commit && !table_full) begin
            live_ff[wp_ff[SLOT_W-1:0]]    <= 1'b1;
            started_ff[wp_ff[SLOT_W-1:0]] <= 1'b0;
            wp_ff <= wp_ff + WP_W'(1);
         end
         if (cmd.calc) begin
            clock_ff <= clock_ff + CW'(slice_in);
            if (!started_ff[scan_ptr_ff]) begin
               started_ff[scan_ptr_ff] <= 1'b1;
               resp_ff <= resp_ff + AW'(clock_ff);
               wait_ff <= wait_ff - WW'(rd_data_ff);
            end
         end
         if (cmd.commit) begin
            fin_ff <= done_now;
            tp_ff  <= slot_next;
            if (done_now) begin
               live_ff[scan_ptr_ff] <= 1'b0;
               turn_ff <= turn_ff + AW'(clock_ff);
               wait_ff <= wait_ff + WW'(clock_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit;
      end
   end

   assign slot_ext  = {4'b0, scan_ptr_ff};
   assign count_ext = {5'b0, wp_ff};

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_task_count     <= count_ext[rrss_pkg::COUNT_W-1:0];
         rsp_sum_turnaround <= turn_ff;
         rsp_sum_waiting    <= wait_ff[AW-1:0];
         rsp_sum_response   <= resp_ff;
         unique case (cmd.kind)
            rrss_pkg::KIND_RUN: begin
               rsp_task_slot     <= slot_ext[rrss_pkg::SLOT_O_W-1:0];
               rsp_slice_length  <= slice_ff;
               rsp_slice_start   <= start_ff[rrss_pkg::START_W-1:0];
               rsp_task_finished <= fin_ff;
               rsp_all_done      <= 1'b0;
               rsp_table_full    <= 1'b0;
            end
            rrss_pkg::KIND_ADD: begin
               rsp_task_slot     <= count_ext[rrss_pkg::SLOT_O_W-1:0]
                                    - rrss_pkg::SLOT_O_W'(1);
               rsp_slice_length  <= '0;
               rsp_slice_start   <= clock_ff[rrss_pkg::START_W-1:0];
               rsp_task_finished <= 1'b0;
               rsp_all_done      <= 1'b0;
               rsp_table_full    <= 1'b0;
            end
            rrss_pkg::KIND_FULL: begin
               rsp_task_slot     <= '0;
               rsp_slice_length  <= '0;
               rsp_slice_start   <= clock_ff[rrss_pkg::START_W-1:0];
               rsp_task_finished <= 1'b0;
               rsp_all_done      <= 1'b0;
               rsp_table_full    <= 1'b1;
            end
            rrss_pkg::KIND_NONE: begin
               rsp_task_slot     <= '0;
               rsp_slice_length  <= '0;
               rsp_slice_start   <= clock_ff[rrss_pkg::START_W-1:0];
               rsp_task_finished <= 1'b0;
               rsp_all_done      <= 1'b1;
               rsp_table_full    <= 1'b0;
            end
            default: begin
               rsp_task_slot     <= '0;
               rsp_slice_length  <= '0;
               rsp_slice_start   <= '0;
               rsp_task_finished <= 1'b0;
               rsp_all_done      <= 1'b0;
               rsp_table_full    <= 1'b0;
            end
         endcase
      end
   end

endmodule

// ===== rtl/round_robin_slice_scheduler_top.sv =====
// Round-robin time-slice scheduler.
// Request: pulse start with req_operation (0 add task, 1 run one slice) and
// req_burst_length while busy is low; the word is taken at that edge.
// Response: one word on the rsp_ ports, marked by rsp_valid for exactly one
// cycle; the receiver cannot hold it off, so it must sample on that cycle.
// Configuration: csr_quantum is written when csr_valid and csr_ready are
// high; csr_ready is always high. Write only while the block is idle.
// Sequence, from the accepting edge to the rsp_valid cycle:
//   add: state ADD, then EMIT, then rsp_valid.
//   run: states SCAN, CALC, COMMIT and EMIT, k being the empty slots skipped from the turn
//        pointer, 0 to MAX_TASKS - 1; the scan tests one slot per cycle.
//   run with no live task: SCAN over every slot, then EMIT.
// busy falls in the rsp_valid cycle, so a new word may start there.
// Reset clears the slot live flags, pointers, clock, totals and sets quantum to 10.
`include "round_robin_slice_scheduler_top_assert.svh"
module round_robin_slice_scheduler_top #(
   parameter int MAX_TASKS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [rrss_pkg::BURST_W-1:0]  req_burst_length,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rrss_pkg::BURST_W-1:0]  csr_quantum,
   output logic                          rsp_valid,
   output logic [rrss_pkg::SLOT_O_W-1:0] rsp_task_slot,
   output logic [rrss_pkg::BURST_W-1:0]  rsp_slice_length,
   output logic [rrss_pkg::START_W-1:0]  rsp_slice_start,
   output logic                          rsp_task_finished,
   output logic                          rsp_all_done,
   output logic                          rsp_table_full,
   output logic [rrss_pkg::COUNT_W-1:0]  rsp_task_count,
   output logic [rrss_pkg::ACC_W-1:0]    rsp_sum_turnaround,
   output logic [rrss_pkg::ACC_W-1:0]    rsp_sum_waiting,
   output logic [rrss_pkg::ACC_W-1:0]    rsp_sum_response
);

   rrss_pkg::cmd_type    cmd;
   rrss_pkg::status_type status;

   assign csr_ready = 1'b1;

   rrss_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .run_req (req_operation),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   rrss_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_valid && csr_ready),
      .csr_quantum        (csr_quantum),
      .req_burst_length   (req_burst_length),
      .rsp_valid          (rsp_valid),
      .rsp_task_slot      (rsp_task_slot),
      .rsp_slice_length   (rsp_slice_length),
      .rsp_slice_start    (rsp_slice_start),
      .rsp_task_finished  (rsp_task_finished),
      .rsp_all_done       (rsp_all_done),
      .rsp_table_full     (rsp_table_full),
      .rsp_task_count     (rsp_task_count),
      .rsp_sum_turnaround (rsp_sum_turnaround),
      .rsp_sum_waiting    (rsp_sum_waiting),
      .rsp_sum_response   (rsp_sum_response)
   );

   `RRSS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `RRSS_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `RRSS_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `RRSS_ASSERT_IMPLY(a_done_empty, clock, reset, rsp_valid && rsp_all_done,
      rsp_slice_length == '0 && !rsp_task_finished && !rsp_table_full)

endmodule

// ===== tb/round_robin_slice_scheduler_top_test.sv =====
module round_robin_slice_scheduler_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_TASKS = 16;
   localparam int PHASE_ITEMS = 380;
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_RUN = 1'b1;

   typedef struct packed {
      logic [rrss_pkg::SLOT_O_W-1:0] slot;
      logic [rrss_pkg::BURST_W-1:0]  len;
      logic [rrss_pkg::START_W-1:0]  start_t;
      logic                          fin;
      logic                          done;
      logic                          full;
      logic [rrss_pkg::COUNT_W-1:0]  count;
      logic [rrss_pkg::ACC_W-1:0]    turnaround;
      logic [rrss_pkg::ACC_W-1:0]    waiting;
      logic [rrss_pkg::ACC_W-1:0]    response;
   } sched_word_type;

   typedef struct packed {
      logic                          op;
      logic [rrss_pkg::BURST_W-1:0]  burst;
      logic                          typed;
      logic [rrss_pkg::SLOT_O_W-1:0] slot;
      logic                          done;
      logic [rrss_pkg::COUNT_W-1:0]  count;
   } stim_row_type;

   stim_row_type directed_rows [15] = '{
      '{OP_RUN, 16'h0000, 1'b1, 4'd0, 1'b1, 5'd0},
      '{OP_ADD, 16'h0000, 1'b1, 4'd0, 1'b0, 5'd1},
      '{OP_ADD, 16'hFFFF, 1'b1, 4'd1, 1'b0, 5'd2},
      '{OP_ADD, 16'h0001, 1'b1, 4'd2, 1'b0, 5'd3},
      '{OP_ADD, 16'd9,    1'b1, 4'd3, 1'b0, 5'd4},
      '{OP_ADD, 16'd10,   1'b1, 4'd4, 1'b0, 5'd5},
      '{OP_ADD, 16'd11,   1'b1, 4'd5, 1'b0, 5'd6},
      '{OP_RUN, 16'hFFFF, 1'b0, 4'd0, 1'b0, 5'd0},
      '{OP_RUN, 16'h0000, 1'b0, 4'd0, 1'b0, 5'd0},
      '{OP_RUN, 16'hA5A5, 1'b0, 4'd0, 1'b0, 5'd0},
      '{OP_RUN, 16'h5A5A, 1'b0, 4'd0, 1'b0, 5'd0},
      '{OP_RUN, 16'h0000, 1'b0, 4'd0, 1'b0, 5'd0},
      '{OP_RUN, 16'h0000, 1'b0, 4'd0, 1'b0, 5'd0},
      '{OP_RUN, 16'h0000, 1'b0, 4'd0, 1'b0, 5'd0},
      '{OP_RUN, 16'h0000, 1'b0, 4'd0, 1'b0, 5'd0}
   };

   int idle_by_phase [5] = '{0, 48, 0, 22, 48};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_operation = OP_ADD;
   logic [rrss_pkg::BURST_W-1:0]    req_burst_length = '0;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [rrss_pkg::BURST_W-1:0]    csr_quantum = rrss_pkg::QUANTUM_RESET;
   logic                            rsp_valid;
   logic [rrss_pkg::SLOT_O_W-1:0]   rsp_task_slot;
   logic [rrss_pkg::BURST_W-1:0]    rsp_slice_length;
   logic [rrss_pkg::START_W-1:0]    rsp_slice_start;
   logic                            rsp_task_finished;
   logic                            rsp_all_done;
   logic                            rsp_table_full;
   logic [rrss_pkg::COUNT_W-1:0]    rsp_task_count;
   logic [rrss_pkg::ACC_W-1:0]      rsp_sum_turnaround;
   logic [rrss_pkg::ACC_W-1:0]      rsp_sum_waiting;
   logic [rrss_pkg::ACC_W-1:0]      rsp_sum_response;

   logic [rrss_pkg::BURST_W-1:0]    task_left [MAX_TASKS];
   logic                            task_live [MAX_TASKS];
   logic                            task_begun [MAX_TASKS];
   logic [rrss_pkg::SLOT_O_W-1:0]   turn_slot = '0;
   logic [rrss_pkg::COUNT_W-1:0]    next_free = '0;
   logic [rrss_pkg::CLOCK_W-1:0]    sched_clock = '0;
   logic [rrss_pkg::ACC_W-1:0]      turnaround_total = '0;
   logic [rrss_pkg::WAIT_W-1:0]     waiting_total = '0;
   logic [rrss_pkg::ACC_W-1:0]      response_total = '0;
   logic [rrss_pkg::BURST_W-1:0]    quantum_reg = rrss_pkg::QUANTUM_RESET;
   int                              live_total = 0;

   sched_word_type                  pending_words [$];
   int                              mismatch_count = 0;

   round_robin_slice_scheduler_top #(
      .MAX_TASKS(MAX_TASKS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_burst_length   (req_burst_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_quantum        (csr_quantum),
      .rsp_valid          (rsp_valid),
      .rsp_task_slot      (rsp_task_slot),
      .rsp_slice_length   (rsp_slice_length),
      .rsp_slice_start    (rsp_slice_start),
      .rsp_task_finished  (rsp_task_finished),
      .rsp_all_done       (rsp_all_done),
      .rsp_table_full     (rsp_table_full),
      .rsp_task_count     (rsp_task_count),
      .rsp_sum_turnaround (rsp_sum_turnaround),
      .rsp_sum_waiting    (rsp_sum_waiting),
      .rsp_sum_response   (rsp_sum_response)
   );

   always #2 clock = ~clock;

   function automatic sched_word_type next_sched_word(
      input logic op, input logic [rrss_pkg::BURST_W-1:0] burst);
      sched_word_type                w;
      logic                          hit;
      logic [rrss_pkg::SLOT_O_W-1:0] s;
      logic [rrss_pkg::SLOT_O_W-1:0] probe;
      logic [rrss_pkg::BURST_W-1:0]  q;
      logic [rrss_pkg::BURST_W-1:0]  slice;
      w = '0;
      w.start_t = sched_clock[rrss_pkg::START_W-1:0];
      if (op == OP_ADD) begin
         if (next_free >= MAX_TASKS) begin
            w.full = 1'b1;
         end else begin
            s = next_free[rrss_pkg::SLOT_O_W-1:0];
            task_left[s] = burst;
            task_live[s] = 1'b1;
            task_begun[s] = 1'b0;
            next_free = next_free + rrss_pkg::COUNT_W'(1);
            live_total++;
            w.slot = s;
         end
      end else begin
         hit = 1'b0;
         s = '0;
         for (int k = 0; k < MAX_TASKS; k++) begin
            probe = turn_slot + k[rrss_pkg::SLOT_O_W-1:0];
            if (!hit && task_live[probe]) begin
               hit = 1'b1;
               s = probe;
            end
         end
         if (!hit) begin
            w.done = 1'b1;
         end else begin
            if (!task_begun[s]) begin
               task_begun[s] = 1'b1;
               response_total = response_total + rrss_pkg::ACC_W'(sched_clock);
               waiting_total = waiting_total - rrss_pkg::WAIT_W'(task_left[s]);
            end
            q = (quantum_reg == '0) ? 16'd1 : quantum_reg;
            slice = (task_left[s] < q) ? task_left[s] : q;
            task_left[s] = task_left[s] - slice;
            sched_clock = sched_clock + rrss_pkg::CLOCK_W'(slice);
            if (task_left[s] == '0) begin
               w.fin = 1'b1;
               task_live[s] = 1'b0;
               live_total--;
               turnaround_total = turnaround_total + rrss_pkg::ACC_W'(sched_clock);
               waiting_total = waiting_total + rrss_pkg::WAIT_W'(sched_clock);
            end
            turn_slot = s + rrss_pkg::SLOT_O_W'(1);
            w.slot = s;
            w.len = slice;
         end
      end
      w.count = next_free;
      w.turnaround = turnaround_total;
      w.waiting = waiting_total[rrss_pkg::ACC_W-1:0];
      w.response = response_total;
      return w;
   endfunction

   task automatic issue_word(input logic op, input logic [rrss_pkg::BURST_W-1:0] burst,
                             input int idle_pct, input logic drain,
                             output sched_word_type predicted);
      if (drain || $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         if (drain) begin
            do @(posedge clock); while (pending_words.size() != 0);
         end else begin
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      start <= 1'b1;
      req_operation <= op;
      req_burst_length <= burst;
      do @(posedge clock); while (busy);
      predicted = next_sched_word(op, burst);
   endtask

   task automatic write_quantum(input logic [rrss_pkg::BURST_W-1:0] value);
      while (pending_words.size() != 0 || busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_quantum <= value;
      do @(posedge clock); while (!csr_ready);
      quantum_reg = value;
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_rsp
      sched_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: slot %0d", rsp_task_slot);
         end else begin
            want = pending_words.pop_front();
            check_field("task_slot", want.slot, rsp_task_slot);
            check_field("slice_length", want.len, rsp_slice_length);
            check_field("slice_start", want.start_t, rsp_slice_start);
            check_field("task_finished", want.fin, rsp_task_finished);
            check_field("all_done", want.done, rsp_all_done);
            check_field("table_full", want.full, rsp_table_full);
            check_field("task_count", want.count, rsp_task_count);
            check_field("sum_turnaround", want.turnaround, rsp_sum_turnaround);
            check_field("sum_waiting", want.waiting, rsp_sum_waiting);
            check_field("sum_response", want.response, rsp_sum_response);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      sched_word_type               w;
      sched_word_type               typed_word;
      logic                         op;
      logic [rrss_pkg::BURST_W-1:0] burst;
      logic [rrss_pkg::BURST_W-1:0] q;
      int                           add_pct;
      for (int i = 0; i < MAX_TASKS; i++) begin
         task_left[i] = '0;
         task_live[i] = 1'b0;
         task_begun[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue_word(directed_rows[i].op, directed_rows[i].burst, 0, 1'b0, w);
         if (directed_rows[i].typed) begin
            typed_word = '0;
            typed_word.slot = directed_rows[i].slot;
            typed_word.done = directed_rows[i].done;
            typed_word.count = directed_rows[i].count;
            pending_words.push_back(typed_word);
         end else begin
            pending_words.push_back(w);
         end
      end
      start <= 1'b0;

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: q = 16'd1;
            1: q = 16'd0;
            2: q = 16'($urandom_range(2, 2000));
            3: q = 16'hFFFF;
            default: q = 16'($urandom_range(100, 65535));
         endcase
         write_quantum(q);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            add_pct = (live_total == 0) ? 40 : 1;
            if ($urandom_range(0, 99) < add_pct) begin
               op = OP_ADD;
               case ($urandom_range(0, 3))
                  0: burst = 16'($urandom_range(0, 3));
                  1: burst = 16'hFFFF - 16'($urandom_range(0, 3));
                  default: burst = 16'($urandom_range(0, 65535));
               endcase
            end else begin
               op = OP_RUN;
               burst = 16'($urandom_range(0, 65535));
            end
            issue_word(op, burst, idle_by_phase[ph],
                       ph == 1 && $urandom_range(0, 99) < 3, w);
            pending_words.push_back(w);
         end
         start <= 1'b0;
      end

      while (pending_words.size() != 0) @(posedge clock);
      repeat (MAX_TASKS + 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rrss_pkg.sv
rtl/rrss_ctrl.sv
rtl/rrss_datapath.sv
rtl/round_robin_slice_scheduler_top.sv
tb/round_robin_slice_scheduler_top_test.sv
